FILE: src/prrs_pkg.sv
// Shared types and codes of the priority round robin scheduler.
package prrs_pkg;

  localparam int CmdW   = 2;
  localparam int BurstW = 16;
  localparam int PrioW  = 8;
  localparam int StatW  = 2;
  localparam int IdW    = 5;
  localparam int ClockW = 20;
  localparam int SumW   = 24;
  localparam int AddrW  = 3;

  // command codes
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CmdW-1:0] CMD_RUN   = 2'd2;
  localparam logic [CmdW-1:0] CMD_NOP   = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_SLICE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatW-1:0] ST_NONE  = 2'd3;

  // register index of the quantum register
  localparam logic REG_QUANTUM = 1'b0;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t item;
  } queue_t;

  typedef struct packed {
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [IdW-1:0]    job_id;
    logic [BurstW-1:0] slice;
    logic              fin;
    logic [ClockW-1:0] wait_t;
    logic [ClockW-1:0] turn;
    logic [ClockW-1:0] clock;
    logic [SumW-1:0]   total_wait;
    logic [SumW-1:0]   total_turn;
  } result_t;

endpackage

FILE: src/prrs_front.sv
// Front end: accepts command beats, drops unused commands, queues the rest.
module prrs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  prrs_pkg::cmd_t in_item_i,
  output prrs_pkg::queue_t q_o,
  input  logic           q_pop_i
);
  import prrs_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o && (in_item_i.cmd != CMD_NOP);
  assign pop  = q_pop_i && (cnt_q != 2'd0);

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: src/prrs_back.sv
// Back end: job table, selection scan, slice accounting and result register.
module prrs_back #(
  parameter int MAX_PROCS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [prrs_pkg::BurstW-1:0]   quantum_i,
  input  prrs_pkg::queue_t              q_i,
  output logic                          q_pop_o,
  output prrs_pkg::result_t             res_o,
  output logic                          res_valid_o,
  input  logic                          res_stall_i
);
  import prrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam logic [CNT_W-1:0] CountMax = CNT_W'(MAX_PROCS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_CLOCK  = 3'd4;
  localparam logic [2:0] S_SETTLE = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  function automatic logic [ClockW-1:0] sat_clock(logic [ClockW-1:0] a, logic [BurstW-1:0] b);
    logic [ClockW:0] s;
    s = {1'b0, a} + (ClockW+1)'(b);
    return s[ClockW] ? {ClockW{1'b1}} : s[ClockW-1:0];
  endfunction

  function automatic logic [SumW-1:0] sat_sum(logic [SumW-1:0] a, logic [ClockW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(b);
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  entry_t mem [MAX_PROCS];
  entry_t rd_q;
  logic   rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic   wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  last_q, last_d;
  logic [ClockW-1:0] clock_q, clock_d;
  logic [SumW-1:0]   wsum_q, wsum_d;
  logic [SumW-1:0]   tsum_q, tsum_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              rvld_q, rvld_d;
  logic [CNT_W-1:0]  ridx_q, ridx_d;
  logic              found_q, found_d;
  logic [PrioW-1:0]  top_q, top_d;
  logic [PrioW-1:0]  lsp_q, lsp_d;
  logic [CNT_W-1:0]  low_idx_q, low_idx_d;
  logic [BurstW-1:0] low_rem_q, low_rem_d;
  logic [BurstW-1:0] low_burst_q, low_burst_d;
  logic              aft_vld_q, aft_vld_d;
  logic [CNT_W-1:0]  aft_idx_q, aft_idx_d;
  logic [BurstW-1:0] aft_rem_q, aft_rem_d;
  logic [BurstW-1:0] aft_burst_q, aft_burst_d;
  logic [CNT_W-1:0]  sel_idx_q, sel_idx_d;
  logic [BurstW-1:0] sel_rem_q, sel_rem_d;
  logic [BurstW-1:0] sel_burst_q, sel_burst_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [CNT_W-1:0]  id_q, id_d;
  logic [BurstW-1:0] slice_q, slice_d;
  logic              fin_q, fin_d;
  logic [ClockW-1:0] wait_q, wait_d;
  logic [ClockW-1:0] turn_q, turn_d;
  result_t           res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic [BurstW-1:0] q_eff;
  logic [BurstW-1:0] slice_c;
  logic [BurstW-1:0] rem_new;
  logic [SumW-1:0]   wsum_new;
  logic              use_aft;
  logic              at_or_after;

  assign q_eff       = (quantum_i == '0) ? BurstW'(1) : quantum_i;
  assign slice_c     = (sel_rem_q > q_eff) ? q_eff : sel_rem_q;
  assign rem_new     = sel_rem_q - slice_c;
  assign wsum_new    = fin_q ? sat_sum(wsum_q, wait_q) : wsum_q;
  assign use_aft     = (last_q != '0) && (lsp_q == top_q) && aft_vld_q;
  assign at_or_after = (ridx_q >= last_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    last_d      = last_q;
    clock_d     = clock_q;
    wsum_d      = wsum_q;
    tsum_d      = tsum_q;
    scan_d      = scan_q;
    rvld_d      = rvld_q;
    ridx_d      = ridx_q;
    found_d     = found_q;
    top_d       = top_q;
    lsp_d       = lsp_q;
    low_idx_d   = low_idx_q;
    low_rem_d   = low_rem_q;
    low_burst_d = low_burst_q;
    aft_vld_d   = aft_vld_q;
    aft_idx_d   = aft_idx_q;
    aft_rem_d   = aft_rem_q;
    aft_burst_d = aft_burst_q;
    sel_idx_d   = sel_idx_q;
    sel_rem_d   = sel_rem_q;
    sel_burst_d = sel_burst_q;
    status_d    = status_q;
    id_d        = id_q;
    slice_d     = slice_q;
    fin_d       = fin_q;
    wait_d      = wait_q;
    turn_d      = turn_q;
    res_d       = res_q;
    res_vld_d   = res_vld_q && res_stall_i;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_q[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    wr_data     = '{burst: q_i.item.burst, prio: q_i.item.prio, rem: q_i.item.burst};

    unique case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          q_pop_o  = 1'b1;
          status_d = ST_OK;
          id_d     = '0;
          slice_d  = '0;
          fin_d    = 1'b0;
          wait_d   = '0;
          turn_d   = '0;
          state_d  = S_EMIT;
          unique case (q_i.item.cmd)
            CMD_CLEAR: begin
              count_d = '0;
              last_d  = '0;
              clock_d = '0;
              wsum_d  = '0;
              tsum_d  = '0;
            end
            CMD_LOAD: begin
              if (count_q < CountMax) begin
                wr_en   = 1'b1;
                count_d = count_q + CNT_W'(1);
                id_d    = count_q + CNT_W'(1);
              end else begin
                status_d = ST_FULL;
              end
            end
            CMD_RUN: begin
              scan_d    = '0;
              rvld_d    = 1'b0;
              found_d   = 1'b0;
              aft_vld_d = 1'b0;
              state_d   = S_SCAN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue one table read per cycle, evaluate the entry read last cycle
        if (scan_q < count_q) begin
          rd_en  = 1'b1;
          scan_d = scan_q + CNT_W'(1);
          rvld_d = 1'b1;
          ridx_d = scan_q;
        end else begin
          rvld_d = 1'b0;
          if (!rvld_q) begin
            state_d = S_PICK;
          end
        end
        if (rvld_q) begin
          if ((ridx_q + CNT_W'(1)) == last_q) begin
            lsp_d = rd_q.prio;
          end
          if (rd_q.rem != '0) begin
            if (!found_q || (rd_q.prio > top_q)) begin
              found_d     = 1'b1;
              top_d       = rd_q.prio;
              low_idx_d   = ridx_q;
              low_rem_d   = rd_q.rem;
              low_burst_d = rd_q.burst;
              aft_vld_d   = at_or_after;
              aft_idx_d   = ridx_q;
              aft_rem_d   = rd_q.rem;
              aft_burst_d = rd_q.burst;
            end else if ((rd_q.prio == top_q) && !aft_vld_q && at_or_after) begin
              aft_vld_d   = 1'b1;
              aft_idx_d   = ridx_q;
              aft_rem_d   = rd_q.rem;
              aft_burst_d = rd_q.burst;
            end
          end
        end
      end
      S_PICK: begin
        if (!found_q) begin
          status_d = ST_NONE;
          state_d  = S_EMIT;
        end else begin
          sel_idx_d   = use_aft ? aft_idx_q : low_idx_q;
          sel_rem_d   = use_aft ? aft_rem_q : low_rem_q;
          sel_burst_d = use_aft ? aft_burst_q : low_burst_q;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        wr_en    = 1'b1;
        wr_addr  = sel_idx_q[IDX_W-1:0];
        wr_data  = '{burst: sel_burst_q, prio: top_q, rem: rem_new};
        last_d   = sel_idx_q + CNT_W'(1);
        id_d     = sel_idx_q + CNT_W'(1);
        status_d = ST_SLICE;
        slice_d  = slice_c;
        fin_d    = (rem_new == '0);
        state_d  = S_CLOCK;
      end
      S_CLOCK: begin
        clock_d = sat_clock(clock_q, slice_q);
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        if (fin_q) begin
          turn_d = clock_q;
          wait_d = (clock_q >= ClockW'(sel_burst_q)) ? clock_q - ClockW'(sel_burst_q) : '0;
          tsum_d = sat_sum(tsum_q, clock_q);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!res_vld_q || !res_stall_i) begin
          wsum_d    = wsum_new;
          res_d     = '{status: status_q, job_id: IdW'(id_q), slice: slice_q, fin: fin_q,
                        wait_t: wait_q, turn: turn_q, clock: clock_q,
                        total_wait: wsum_new, total_turn: tsum_q};
          res_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      last_q    <= '0;
      clock_q   <= '0;
      wsum_q    <= '0;
      tsum_q    <= '0;
      scan_q    <= '0;
      rvld_q    <= 1'b0;
      found_q   <= 1'b0;
      aft_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      last_q    <= last_d;
      clock_q   <= clock_d;
      wsum_q    <= wsum_d;
      tsum_q    <= tsum_d;
      scan_q    <= scan_d;
      rvld_q    <= rvld_d;
      found_q   <= found_d;
      aft_vld_q <= aft_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q      <= ridx_d;
    top_q       <= top_d;
    lsp_q       <= lsp_d;
    low_idx_q   <= low_idx_d;
    low_rem_q   <= low_rem_d;
    low_burst_q <= low_burst_d;
    aft_idx_q   <= aft_idx_d;
    aft_rem_q   <= aft_rem_d;
    aft_burst_q <= aft_burst_d;
    sel_idx_q   <= sel_idx_d;
    sel_rem_q   <= sel_rem_d;
    sel_burst_q <= sel_burst_d;
    status_q    <= status_d;
    id_q        <= id_d;
    slice_q     <= slice_d;
    fin_q       <= fin_d;
    wait_q      <= wait_d;
    turn_q      <= turn_d;
    res_q       <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

endmodule

FILE: src/priority_round_robin_scheduler_core.sv
// Top level of the priority round robin scheduler: config register, front and back ends.
//
//  channel   direction  handshake                    payload
//  in        input      in_valid_i / in_stall_o      cmd_i, burst_length_i, job_priority_i
//  out       output     out_valid_o / out_stall_i    status_o ... total_turnaround_o
//  config    input      psel, penable, pwrite/pready paddr, pwdata, prdata (slice quantum)
//
// A clear or load command passes through the front queue to the back end, which then
// loads the result register.
// A run command reaches the back end, reads the job table one entry per cycle through
// a single registered memory port, picks the job, then takes four steps on the slice,
// clock and totals, or goes from the pick straight to the result if nothing is left.
// Up to two commands queue in the front while the back works.
// Reset is asynchronous and active low; the job table needs no clearing pass.
// A stalled result holds in the output register; the front keeps taking beats until
// its queue fills. Unused command code 3 is accepted and dropped without a result.
module priority_round_robin_scheduler_core #(
  parameter int MAX_PROCS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [prrs_pkg::CmdW-1:0]     cmd_i,
  input  logic [prrs_pkg::BurstW-1:0]   burst_length_i,
  input  logic [prrs_pkg::PrioW-1:0]    job_priority_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prrs_pkg::StatW-1:0]    status_o,
  output logic [prrs_pkg::IdW-1:0]      job_id_o,
  output logic [prrs_pkg::BurstW-1:0]   slice_length_o,
  output logic                          job_finished_o,
  output logic [prrs_pkg::ClockW-1:0]   wait_time_o,
  output logic [prrs_pkg::ClockW-1:0]   turnaround_o,
  output logic [prrs_pkg::ClockW-1:0]   clock_now_o,
  output logic [prrs_pkg::SumW-1:0]     total_wait_o,
  output logic [prrs_pkg::SumW-1:0]     total_turnaround_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prrs_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import prrs_pkg::*;

  logic [BurstW-1:0] quantum_q, quantum_d;
  logic              cfg_wr;
  cmd_t              in_item;
  queue_t            queue;
  logic              q_pop;
  result_t           res;

  // Quantum register: written on the access phase of an APB write to its slot.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QUANTUM);
  assign quantum_d = cfg_wr ? pwdata[BurstW-1:0] : quantum_q;
  assign prdata = (paddr[2] == REG_QUANTUM) ? {{(32-BurstW){1'b0}}, quantum_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= BurstW'(4);
    end else begin
      quantum_q <= quantum_d;
    end
  end

  // Pack the command beat for the front end queue.
  assign in_item = '{cmd: cmd_i, burst: burst_length_i, prio: job_priority_i};

  prrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_o        (queue),
    .q_pop_i    (q_pop)
  );

  // Back end: clear or load the table, or scan it, run one slice and update the clock and totals.
  prrs_back #(
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quantum_i   (quantum_q),
    .q_i         (queue),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i)
  );

  // Unpack the registered result beat.
  assign status_o           = res.status;
  assign job_id_o           = res.job_id;
  assign slice_length_o     = res.slice;
  assign job_finished_o     = res.fin;
  assign wait_time_o        = res.wait_t;
  assign turnaround_o       = res.turn;
  assign clock_now_o        = res.clock;
  assign total_wait_o       = res.total_wait;
  assign total_turnaround_o = res.total_turn;

`ifndef NO_ASSERTIONS
  // the back end pops only a queued command
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> queue.valid) else $error("pop from empty command queue");

  // a slice names a job (checked when MAX_PROCS < 32) and runs for at least one time unit
  a_slice_named: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_SLICE) && (MAX_PROCS < 32))
      |-> ((job_id_o != '0) && (slice_length_o != '0)))
    else $error("slice result without job or length");

  // only a slice can carry a length or a completion
  a_no_slice_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_SLICE))
      |-> ((slice_length_o == '0) && !job_finished_o && (turnaround_o == '0)))
    else $error("non-slice result carries slice fields");

  // a finished job reports the current clock as its turnaround and a wait no longer than it
  a_finish_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && job_finished_o)
      |-> ((turnaround_o == clock_now_o) && (wait_time_o <= turnaround_o)))
    else $error("finished job timing inconsistent");
`endif

endmodule
